// File: rtl/ttv_pkg.sv
// ----------------------------------------------------------------------------
// ttv_pkg
// Shared widths, register indexes and types of the triangle tangent unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ttv_pkg;

   // field widths
   localparam int POS_W  = 32;
   localparam int TEX_W  = 16;
   localparam int DIFF_W = POS_W + 1;   // position edge
   localparam int TD_W   = TEX_W + 1;   // texture difference
   localparam int OUT_W  = 16;
   localparam int EPS_W  = 21;

   // configuration register file
   localparam int                 CSR_IDX_W       = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DET_EPSILON = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_TEX_T  = 2'd1;
   localparam logic [EPS_W-1:0]   EPS_RESET       = 21'd1678;
   localparam logic               FLIP_RESET      = 1'b1;

   // depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // one vertex as held by the front
   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic signed [TEX_W-1:0] s;
      logic signed [TEX_W-1:0] t;
   } vertex_type;

   // one triangle's differences, handed from front to back
   typedef struct packed {
      logic signed [DIFF_W-1:0] px;
      logic signed [DIFF_W-1:0] py;
      logic signed [DIFF_W-1:0] pz;
      logic signed [DIFF_W-1:0] qx;
      logic signed [DIFF_W-1:0] qy;
      logic signed [DIFF_W-1:0] qz;
      logic signed [TD_W-1:0]   s1;
      logic signed [TD_W-1:0]   t1;
      logic signed [TD_W-1:0]   s2;
      logic signed [TD_W-1:0]   t2;
   } job_type;

   // configuration as seen by front and back
   typedef struct packed {
      logic [EPS_W-1:0] det_epsilon;
      logic             flip_tex_t;
   } csr_type;

endpackage

`default_nettype wire

// File: rtl/triangle_tangent_vector_unit.sv
// ----------------------------------------------------------------------------
// triangle_tangent_vector_unit
// Per-triangle unit tangent from a stream of textured vertices.
// ----------------------------------------------------------------------------
// Vertices are transferred one per cycle while the job queue has room, and
// are grouped in threes; each third vertex queues one triangle, and one Q2.14
// tangent comes out per triangle. Most of the back end's work is the search
// for the three normalized components, 15 bits each, bit by bit through the
// trial, product and compare states of the one squaring and product unit;
// it follows magnitude scaling and is skipped when the tangent is zero. A
// finished tangent waits in the output register and the back end stalls
// until it is popped. The front keeps accepting vertices while the two-entry
// job queue has room. Write configuration only while idle.
`default_nettype none

module triangle_tangent_vector_unit #(
   parameter int QUEUE_DEPTH = ttv_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [ttv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ttv_pkg::EPS_W-1:0]         csr_wdata,
   input  wire logic                              push,
   output logic                                   full,
   input  wire logic signed [ttv_pkg::POS_W-1:0]  req_pos_x,
   input  wire logic signed [ttv_pkg::POS_W-1:0]  req_pos_y,
   input  wire logic signed [ttv_pkg::POS_W-1:0]  req_pos_z,
   input  wire logic signed [ttv_pkg::TEX_W-1:0]  req_tex_s,
   input  wire logic signed [ttv_pkg::TEX_W-1:0]  req_tex_t,
   input  wire logic                              req_mesh_start,
   output logic                                   empty,
   input  wire logic                              pop,
   output logic signed [ttv_pkg::OUT_W-1:0]       rsp_tangent_x,
   output logic signed [ttv_pkg::OUT_W-1:0]       rsp_tangent_y,
   output logic signed [ttv_pkg::OUT_W-1:0]       rsp_tangent_z,
   output logic                                   rsp_small_det
);
   import ttv_pkg::*;

   csr_type csr_ff, csr_in;
   job_type front_job, queue_job;
   logic    job_push, job_full, job_pop, job_empty;

   // configuration writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DET_EPSILON: csr_in.det_epsilon = csr_wdata;
            CSR_FLIP_TEX_T:  csr_in.flip_tex_t  = csr_wdata[0];
            default:         csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.det_epsilon <= EPS_RESET;
         csr_ff.flip_tex_t  <= FLIP_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   ttv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .push       (push),
      .full       (full),
      .pos_x      (req_pos_x),
      .pos_y      (req_pos_y),
      .pos_z      (req_pos_z),
      .tex_s      (req_tex_s),
      .tex_t      (req_tex_t),
      .mesh_start (req_mesh_start),
      .job_push   (job_push),
      .job        (front_job),
      .job_full   (job_full)
   );

   ttv_job_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (front_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (queue_job),
      .empty     (job_empty)
   );

   ttv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .job_empty (job_empty),
      .job       (queue_job),
      .job_pop   (job_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .tangent_x (rsp_tangent_x),
      .tangent_y (rsp_tangent_y),
      .tangent_z (rsp_tangent_z),
      .small_det (rsp_small_det)
   );

endmodule

`default_nettype wire

// File: rtl/ttv_front.sv
// ----------------------------------------------------------------------------
// ttv_front
// Groups vertices in threes and forms the edge and texture differences.
// ----------------------------------------------------------------------------
`default_nettype none

module ttv_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ttv_pkg::csr_type              csr,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic signed [ttv_pkg::POS_W-1:0] pos_x,
   input  wire logic signed [ttv_pkg::POS_W-1:0] pos_y,
   input  wire logic signed [ttv_pkg::POS_W-1:0] pos_z,
   input  wire logic signed [ttv_pkg::TEX_W-1:0] tex_s,
   input  wire logic signed [ttv_pkg::TEX_W-1:0] tex_t,
   input  wire logic                          mesh_start,
   output logic                               job_push,
   output ttv_pkg::job_type                   job,
   input  wire logic                          job_full
);
   import ttv_pkg::*;

   logic [1:0]  count_ff, count_in, count_eff;
   vertex_type  held0_ff, held0_in, held1_ff, held1_in, cur;
   logic        accept;
   logic signed [TD_W-1:0] dt1, dt2;

   assign full   = job_full;
   assign accept = push && !job_full;

   // current vertex and effective group position
   always_comb begin
      cur.x = pos_x;
      cur.y = pos_y;
      cur.z = pos_z;
      cur.s = tex_s;
      cur.t = tex_t;
      count_eff = mesh_start ? 2'd0 : count_ff;
   end

   // hold the first two vertices, drop the group on the third
   always_comb begin
      count_in = count_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      if (accept) begin
         if (count_eff == 2'd0) begin
            held0_in = cur;
            count_in = 2'd1;
         end else if (count_eff == 2'd1) begin
            held1_in = cur;
            count_in = 2'd2;
         end else begin
            count_in = 2'd0;
         end
      end
   end

   // differences of the completed triangle
   always_comb begin
      dt1 = {held1_ff.t[TEX_W-1], held1_ff.t} - {held0_ff.t[TEX_W-1], held0_ff.t};
      dt2 = {cur.t[TEX_W-1], cur.t} - {held0_ff.t[TEX_W-1], held0_ff.t};
      job.px = {held1_ff.x[POS_W-1], held1_ff.x} - {held0_ff.x[POS_W-1], held0_ff.x};
      job.py = {held1_ff.y[POS_W-1], held1_ff.y} - {held0_ff.y[POS_W-1], held0_ff.y};
      job.pz = {held1_ff.z[POS_W-1], held1_ff.z} - {held0_ff.z[POS_W-1], held0_ff.z};
      job.qx = {cur.x[POS_W-1], cur.x} - {held0_ff.x[POS_W-1], held0_ff.x};
      job.qy = {cur.y[POS_W-1], cur.y} - {held0_ff.y[POS_W-1], held0_ff.y};
      job.qz = {cur.z[POS_W-1], cur.z} - {held0_ff.z[POS_W-1], held0_ff.z};
      job.s1 = {held1_ff.s[TEX_W-1], held1_ff.s} - {held0_ff.s[TEX_W-1], held0_ff.s};
      job.s2 = {cur.s[TEX_W-1], cur.s} - {held0_ff.s[TEX_W-1], held0_ff.s};
      job.t1 = csr.flip_tex_t ? -dt1 : dt1;
      job.t2 = csr.flip_tex_t ? -dt2 : dt2;
      job_push = accept && (count_eff == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

endmodule

`default_nettype wire

// File: rtl/ttv_job_queue.sv
// ----------------------------------------------------------------------------
// ttv_job_queue
// Short queue of triangle jobs between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ttv_job_queue #(
   parameter int DEPTH = ttv_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ttv_pkg::job_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output ttv_pkg::job_type      pop_data,
   output logic                  empty
);
   import ttv_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_COUNT);
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ttv_back.sv
// ----------------------------------------------------------------------------
// ttv_back
// Sequencer that computes, scales and normalizes one triangle's tangent.
// ----------------------------------------------------------------------------
`default_nettype none

module ttv_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ttv_pkg::csr_type           csr,
   input  wire logic                       job_empty,
   input  wire ttv_pkg::job_type           job,
   output logic                            job_pop,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic signed [ttv_pkg::OUT_W-1:0] tangent_x,
   output logic signed [ttv_pkg::OUT_W-1:0] tangent_y,
   output logic signed [ttv_pkg::OUT_W-1:0] tangent_z,
   output logic                            small_det
);
   import ttv_pkg::*;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_DET_MUL = 4'd1;
   localparam logic [3:0] ST_DET_SUB = 4'd2;
   localparam logic [3:0] ST_C_MUL   = 4'd3;
   localparam logic [3:0] ST_C_SUB   = 4'd4;
   localparam logic [3:0] ST_SCALE   = 4'd5;
   localparam logic [3:0] ST_SQ      = 4'd6;
   localparam logic [3:0] ST_SUM     = 4'd7;
   localparam logic [3:0] ST_NB_D    = 4'd8;
   localparam logic [3:0] ST_NB_P    = 4'd9;
   localparam logic [3:0] ST_NB_C    = 4'd10;
   localparam logic [3:0] ST_FINISH  = 4'd11;

   localparam int MAG_W = 51;
   localparam int PRD_W = 50;
   localparam logic [14:0] UNIT_ONE = 15'd16384;

   logic [3:0]  state_ff, state_in;
   job_type     job_ff, job_in;
   logic [1:0]  idx_ff, idx_in;
   logic signed [PRD_W-1:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic        small_ff, small_in, neg_ff, neg_in, zero_ff, zero_in;
   logic [MAG_W-1:0] mag_ff [3];
   logic [MAG_W-1:0] mag_in [3];
   logic        sgn_ff [3];
   logic        sgn_in [3];
   logic [31:0] a2_ff [3];
   logic [31:0] a2_in [3];
   logic [14:0] res_ff [3];
   logic [14:0] res_in [3];
   logic [33:0] len2_ff, len2_in;
   logic [31:0] d2_ff, d2_in;
   logic [48:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [14:0] r_ff, r_in, cand_ff, cand_in;
   logic [3:0]  bit_ff, bit_in;
   logic        out_valid_ff, out_valid_in;
   logic signed [OUT_W-1:0] tx_ff, tx_in, ty_ff, ty_in, tz_ff, tz_in;
   logic        sd_ff, sd_in;

   logic signed [DIFF_W-1:0] p_sel, q_sel;
   logic signed [MAG_W-1:0]  diff;
   logic [MAG_W-1:0] dmag, m01, mx;
   logic [15:0] a_sel, dval;
   logic [14:0] cand_c;
   logic [65:0] prod, target;
   logic        fits;

   assign rsp_empty = !out_valid_ff;
   assign tangent_x = tx_ff;
   assign tangent_y = ty_ff;
   assign tangent_z = tz_ff;
   assign small_det = sd_ff;

   // shared operand selection and wide arithmetic
   always_comb begin
      case (idx_ff)
         2'd0:    begin p_sel = job_ff.px; q_sel = job_ff.qx; end
         2'd1:    begin p_sel = job_ff.py; q_sel = job_ff.qy; end
         default: begin p_sel = job_ff.pz; q_sel = job_ff.qz; end
      endcase
      diff   = {mul_a_ff[PRD_W-1], mul_a_ff} - {mul_b_ff[PRD_W-1], mul_b_ff};
      dmag   = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      m01    = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
      mx     = (m01 > mag_ff[2]) ? m01 : mag_ff[2];
      a_sel  = mag_ff[idx_ff][15:0];
      cand_c = r_ff | (15'd1 << bit_ff);
      dval   = {cand_c, 1'b0} - 16'd1;
      prod   = {phi_ff, 17'd0} + {17'd0, plo_ff};
      target = {4'd0, a2_ff[idx_ff], 30'd0};
      fits   = (cand_ff <= UNIT_ONE) && (prod <= target);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      small_in     = small_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      mag_in       = mag_ff;
      sgn_in       = sgn_ff;
      a2_in        = a2_ff;
      res_in       = res_ff;
      len2_in      = len2_ff;
      d2_in        = d2_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      r_in         = r_ff;
      cand_in      = cand_ff;
      bit_in       = bit_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      tz_in        = tz_ff;
      sd_in        = sd_ff;
      job_pop      = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;

      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_in   = job;
               job_pop  = 1'b1;
               state_in = ST_DET_MUL;
            end
         end
         ST_DET_MUL: begin
            mul_a_in = PRD_W'(job_ff.s1 * job_ff.t2);
            mul_b_in = PRD_W'(job_ff.s2 * job_ff.t1);
            state_in = ST_DET_SUB;
         end
         ST_DET_SUB: begin
            small_in = (dmag <= MAG_W'(csr.det_epsilon));
            neg_in   = diff[MAG_W-1] && (dmag > MAG_W'(csr.det_epsilon));
            idx_in   = 2'd0;
            state_in = ST_C_MUL;
         end
         ST_C_MUL: begin
            mul_a_in = PRD_W'(job_ff.t2 * p_sel);
            mul_b_in = PRD_W'(job_ff.t1 * q_sel);
            state_in = ST_C_SUB;
         end
         ST_C_SUB: begin
            mag_in[idx_ff] = dmag;
            sgn_in[idx_ff] = (diff[MAG_W-1] ^ neg_ff) && (dmag != '0);
            if (idx_ff == 2'd2) begin
               state_in = ST_SCALE;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_C_MUL;
            end
         end
         ST_SCALE: begin
            // shift all magnitudes until the largest fits in 16 bits
            zero_in = (mx == '0);
            if (mx == '0) begin
               state_in = ST_FINISH;
            end else if (mx >= MAG_W'(2**24)) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 8;
            end else if (mx >= MAG_W'(2**16)) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else begin
               idx_in   = 2'd0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            a2_in[idx_ff] = a_sel * a_sel;
            if (idx_ff == 2'd2) begin
               state_in = ST_SUM;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         ST_SUM: begin
            len2_in  = {2'd0, a2_ff[0]} + {2'd0, a2_ff[1]} + {2'd0, a2_ff[2]};
            idx_in   = 2'd0;
            r_in     = '0;
            bit_in   = 4'd14;
            state_in = ST_NB_D;
         end
         ST_NB_D: begin
            // set the trial bit and square 2*cand-1
            cand_in  = cand_c;
            d2_in    = dval * dval;
            state_in = ST_NB_P;
         end
         ST_NB_P: begin
            // partial products of the new d2 land this cycle
            state_in = ST_NB_C;
         end
         ST_NB_C: begin
            // plo/phi hold d2 * len2 of this candidate
            if (fits) r_in = cand_ff;
            if (bit_ff == 4'd0) begin
               res_in[idx_ff] = fits ? cand_ff : r_ff;
               if (idx_ff == 2'd2) begin
                  state_in = ST_FINISH;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  r_in     = '0;
                  bit_in   = 4'd14;
                  state_in = ST_NB_D;
               end
            end else begin
               bit_in   = bit_ff - 4'd1;
               state_in = ST_NB_D;
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff) begin
               tx_in = zero_ff ? '0 : (sgn_ff[0] ? -OUT_W'({1'b0, res_ff[0]})
                                                 : OUT_W'({1'b0, res_ff[0]}));
               ty_in = zero_ff ? '0 : (sgn_ff[1] ? -OUT_W'({1'b0, res_ff[1]})
                                                 : OUT_W'({1'b0, res_ff[1]}));
               tz_in = zero_ff ? '0 : (sgn_ff[2] ? -OUT_W'({1'b0, res_ff[2]})
                                                 : OUT_W'({1'b0, res_ff[2]}));
               sd_in        = small_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // partial products of d2 * len2, registered from d2 and held while in NB_C
      if (state_ff == ST_NB_C) begin
         plo_in = plo_ff;
         phi_in = phi_ff;
      end else begin
         plo_in = d2_ff * len2_ff[16:0];
         phi_in = d2_ff * len2_ff[33:17];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff   <= job_in;
      idx_ff   <= idx_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      small_ff <= small_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      mag_ff   <= mag_in;
      sgn_ff   <= sgn_in;
      a2_ff    <= a2_in;
      res_ff   <= res_in;
      len2_ff  <= len2_in;
      d2_ff    <= d2_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      r_ff     <= r_in;
      cand_ff  <= cand_in;
      bit_ff   <= bit_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      tz_ff    <= tz_in;
      sd_ff    <= sd_in;
   end

endmodule

`default_nettype wire

// File: rtl/ttv_checker.sv
// ----------------------------------------------------------------------------
// ttv_checker
// Port-level checks of the tangent unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttv_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               empty,
   input wire logic               pop,
   input wire logic signed [15:0] rsp_tangent_x,
   input wire logic signed [15:0] rsp_tangent_y,
   input wire logic signed [15:0] rsp_tangent_z,
   input wire logic               rsp_small_det
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result present after reset");

   // a waiting result holds until transferred
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> $stable({rsp_tangent_x, rsp_tangent_y, rsp_tangent_z,
                                  rsp_small_det}))
      else $error("waiting result changed");

   // components stay within one unit
   a_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_tangent_x >= -16'sd16384) && (rsp_tangent_x <= 16'sd16384) &&
                 (rsp_tangent_y >= -16'sd16384) && (rsp_tangent_y <= 16'sd16384) &&
                 (rsp_tangent_z >= -16'sd16384) && (rsp_tangent_z <= 16'sd16384))
      else $error("tangent component out of range");

   // a nonzero tangent is normalized: its largest component is big
   a_norm: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_tangent_x == 0) && (rsp_tangent_y == 0) && (rsp_tangent_z == 0)) ||
                 (rsp_tangent_x >= 16'sd8192) || (rsp_tangent_x <= -16'sd8192) ||
                 (rsp_tangent_y >= 16'sd8192) || (rsp_tangent_y <= -16'sd8192) ||
                 (rsp_tangent_z >= 16'sd8192) || (rsp_tangent_z <= -16'sd8192))
      else $error("tangent not normalized");

endmodule

bind triangle_tangent_vector_unit ttv_checker u_ttv_checker (
   .clock         (clock),
   .reset         (reset),
   .empty         (empty),
   .pop           (pop),
   .rsp_tangent_x (rsp_tangent_x),
   .rsp_tangent_y (rsp_tangent_y),
   .rsp_tangent_z (rsp_tangent_z),
   .rsp_small_det (rsp_small_det)
);

`default_nettype wire
